@@ hdl/kvtl_pkg.sv @@
`default_nettype none
package kvtl_pkg;

    localparam int unsigned CAPACITY_DEFAULT = 16;
    localparam int unsigned LIMIT_W          = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_FIND   = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;

    localparam logic [2:0] ST_APPENDED   = 3'd0;
    localparam logic [2:0] ST_OVERWRITE  = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_FOUND      = 3'd3;
    localparam logic [2:0] ST_MISS       = 3'd4;
    localparam logic [2:0] ST_DELETED    = 3'd5;
    localparam logic [2:0] ST_ABSENT     = 3'd6;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] value_in;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value_out;
        logic [4:0]  count_out;
    } t_rsp;

endpackage
`default_nettype wire

@@ hdl/key_value_table_linear_core.sv @@
// Key-value table kept as a packed, unsorted array of up to CAPACITY entries.
// Input channel: i_in_valid / o_in_ready carry one request item (func, key,
// value_in). Output channel: o_out_valid / i_out_ready carry one response
// item (status, value_out, count_out) for every request.
// Operations: insert overwrites a matching key or appends a new one (rejected
// when the count has reached the limit), find returns the stored value,
// delete removes the match and moves every later entry down one slot.
// One item is worked at a time; o_in_ready is low while it is in flight.
// The entries are scanned one at a time through a single read port of the
// key and value memories: each entry examined is read and then compared, and
// each entry moved on delete is read and then written one slot lower.
// The response sits in an output register; the next item is taken while it
// waits, and the block holds its next response until the receiver takes it.
// i_cfg_we writes the entry limit (reset 16, clamped to CAPACITY); write it
// only while the block is idle.
// Reset (synchronous, active low) empties the table and sets the limit to
// 16; the memory contents are not cleared, since only slots below the
// count are ever used.
`default_nettype none
module key_value_table_linear_core #(
    parameter int unsigned CAPACITY = kvtl_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [kvtl_pkg::LIMIT_W-1:0] i_cfg_data,
    input  wire logic                        i_in_valid,
    output      logic                        o_in_ready,
    input  wire kvtl_pkg::t_req              i_in_item,
    output      logic                        o_out_valid,
    input  wire logic                        i_out_ready,
    output      kvtl_pkg::t_rsp              o_out_item
);

    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CMPW = (CW > kvtl_pkg::LIMIT_W) ? CW : kvtl_pkg::LIMIT_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOOK = 6'b000010,
        S_CMP  = 6'b000100,
        S_SHRD = 6'b001000,
        S_SHWR = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    kvtl_pkg::t_req             r_req;
    logic [CW-1:0]              r_idx, n_idx;
    logic [CW-1:0]              r_count, n_count;
    logic [kvtl_pkg::LIMIT_W-1:0] r_limit;
    kvtl_pkg::t_rsp             r_res, n_res;
    kvtl_pkg::t_rsp             r_out, n_out;
    logic                       r_ovalid, n_ovalid;
    logic [31:0]                r_key_q, r_val_q;
    logic [31:0]                key_mem [CAPACITY];
    logic [31:0]                val_mem [CAPACITY];

    logic                       key_we, val_we;
    logic [IW-1:0]              waddr;
    logic [31:0]                wkey, wval;
    logic [CW-1:0]              idx_p1, idx_m1, count_p1, count_m1;
    logic                       room, in_acc;

    assign in_acc   = i_in_valid && o_in_ready;
    assign idx_p1   = CW'(r_idx + 1'b1);
    assign idx_m1   = CW'(r_idx - 1'b1);
    assign count_p1 = CW'(r_count + 1'b1);
    assign count_m1 = CW'(r_count - 1'b1);
    assign room     = (CMPW'(r_count) < CMPW'(r_limit)) && (r_count < CW'(CAPACITY));

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_count  = r_count;
        n_res    = r_res;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        key_we   = 1'b0;
        val_we   = 1'b0;
        waddr    = r_idx[IW-1:0];
        wkey     = r_req.key;
        wval     = r_req.value_in;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx   = '0;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_res.value_out = '0;
                n_res.count_out = 5'(r_count);
                if (r_req.func != kvtl_pkg::FUNC_INSERT && r_req.func != kvtl_pkg::FUNC_FIND
                        && r_req.func != kvtl_pkg::FUNC_DELETE) begin
                    n_res.status = kvtl_pkg::ST_MISS;
                    n_state      = S_DONE;
                end else if (r_idx == r_count) begin
                    n_state = S_DONE;
                    case (r_req.func)
                        kvtl_pkg::FUNC_INSERT: begin
                            if (room) begin
                                key_we          = 1'b1;
                                val_we          = 1'b1;
                                n_count         = count_p1;
                                n_res.count_out = 5'(count_p1);
                                n_res.status    = kvtl_pkg::ST_APPENDED;
                            end else begin
                                n_res.status = kvtl_pkg::ST_FULL;
                            end
                        end
                        kvtl_pkg::FUNC_DELETE: n_res.status = kvtl_pkg::ST_ABSENT;
                        default:               n_res.status = kvtl_pkg::ST_MISS;
                    endcase
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_key_q == r_req.key) begin
                    n_state = S_DONE;
                    case (r_req.func)
                        kvtl_pkg::FUNC_INSERT: begin
                            val_we       = 1'b1;
                            n_res.status = kvtl_pkg::ST_OVERWRITE;
                        end
                        kvtl_pkg::FUNC_FIND: begin
                            n_res.status    = kvtl_pkg::ST_FOUND;
                            n_res.value_out = r_val_q;
                        end
                        default: begin
                            if (idx_p1 < r_count) begin
                                n_idx   = idx_p1;
                                n_state = S_SHRD;
                            end else begin
                                n_count         = count_m1;
                                n_res.count_out = 5'(count_m1);
                                n_res.status    = kvtl_pkg::ST_DELETED;
                            end
                        end
                    endcase
                end else begin
                    n_idx   = idx_p1;
                    n_state = S_LOOK;
                end
            end
            S_SHRD: begin
                n_state = S_SHWR;
            end
            S_SHWR: begin
                key_we = 1'b1;
                val_we = 1'b1;
                waddr  = idx_m1[IW-1:0];
                wkey   = r_key_q;
                wval   = r_val_q;
                if (idx_p1 < r_count) begin
                    n_idx   = idx_p1;
                    n_state = S_SHRD;
                end else begin
                    n_count         = count_m1;
                    n_res.count_out = 5'(count_m1);
                    n_res.status    = kvtl_pkg::ST_DELETED;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_limit  <= kvtl_pkg::LIMIT_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_res <= n_res;
        r_out <= n_out;
        if (in_acc) begin
            r_req <= i_in_item;
        end
    end

    // one write and one read port per memory
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[waddr] <= wkey;
        end
        r_key_q <= key_mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            val_mem[waddr] <= wval;
        end
        r_val_q <= val_mem[r_idx[IW-1:0]];
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOOK && r_state != S_CMP && r_state != S_SHWR) |=> $stable(r_count))
        else $error("entry count changed outside an operation");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != kvtl_pkg::ST_FOUND) |-> (o_out_item.value_out == '0))
        else $error("value on a response other than found");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("ready again right after an accepted item");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP || r_state == S_SHRD || r_state == S_SHWR) |-> (r_idx < r_count))
        else $error("scan index beyond the count");

endmodule
`default_nettype wire
